// ----- rtl/ilid_pkg.sv -----
// shared types, constants and the microcode rom of the indexed list block
// no dependencies; imported by rtl/indexed_list_insert_delete.sv
package ilid_pkg;

   localparam int WORD_W  = 32;
   localparam int POS_W   = 8;
   localparam int TOTAL_W = 7;
   localparam int STAT_W  = 2;

   localparam logic [TOTAL_W-1:0] CSR_INIT_RESET = 7'd4;

   typedef enum logic [2:0] {
      OP_APPEND    = 3'd0,
      OP_INSERT    = 3'd1,
      OP_DELETE    = 3'd2,
      OP_READ      = 3'd3,
      OP_OVERWRITE = 3'd4,
      OP_SEARCH    = 3'd5,
      OP_CLEAR     = 3'd6
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RA_PTR, RA_PTR_M1, RA_PTR_P1, RA_POS
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_PTR, WA_POS, WA_CNT
   } wa_sel_type;

   typedef enum logic {
      WD_VAL, WD_RDATA
   } wd_sel_type;

   typedef enum logic [2:0] {
      PTR_KEEP, PTR_LOAD_POS, PTR_LOAD_CNT, PTR_ZERO, PTR_INC, PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      CNT_KEEP, CNT_INC, CNT_DEC, CNT_ZERO
   } cnt_op_type;

   typedef enum logic [1:0] {
      CAP_KEEP, CAP_GROW, CAP_SHRINK, CAP_INIT
   } cap_op_type;

   typedef enum logic [1:0] {
      DATA_ZERO, DATA_RDATA, DATA_PTR
   } data_sel_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_PTR_LE_POS,
      COND_PTR_P1_GE_CNT,
      COND_PTR_P1_LT_CNT,
      COND_MATCH
   } cond_type;

   typedef logic [4:0] upc_type;

   typedef struct packed {
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wa_sel_type   wa_sel;
      wd_sel_type   wd_sel;
      ptr_op_type   ptr_op;
      cnt_op_type   cnt_op;
      cap_op_type   cap_op;
      data_sel_type data_sel;
      status_type   status;
      cond_type     cond;
      upc_type      target;
      logic         done;
   } ucode_type;

   // microcode addresses
   localparam upc_type U_DISP      = 5'd0;
   localparam upc_type U_NOP       = 5'd1;
   localparam upc_type U_ERR_POS   = 5'd2;
   localparam upc_type U_ERR_FULL  = 5'd3;
   localparam upc_type U_ERR_MISS  = 5'd4;
   localparam upc_type U_APP       = 5'd5;
   localparam upc_type U_INS       = 5'd6;
   localparam upc_type U_INS_CHK   = 5'd7;
   localparam upc_type U_INS_RD    = 5'd8;
   localparam upc_type U_INS_WB    = 5'd9;
   localparam upc_type U_INS_PUT   = 5'd10;
   localparam upc_type U_DEL       = 5'd11;
   localparam upc_type U_DEL_CHK   = 5'd12;
   localparam upc_type U_DEL_RD    = 5'd13;
   localparam upc_type U_DEL_WB    = 5'd14;
   localparam upc_type U_DEL_FIN   = 5'd15;
   localparam upc_type U_RD        = 5'd16;
   localparam upc_type U_RD_CAP    = 5'd17;
   localparam upc_type U_WR        = 5'd18;
   localparam upc_type U_SRCH      = 5'd19;
   localparam upc_type U_SRCH_RD   = 5'd20;
   localparam upc_type U_SRCH_CMP  = 5'd21;
   localparam upc_type U_SRCH_NXT  = 5'd22;
   localparam upc_type U_SRCH_MISS = 5'd23;
   localparam upc_type U_SRCH_HIT  = 5'd24;
   localparam upc_type U_CLR       = 5'd25;

   // control store; unused addresses finish the item with nothing changed
   function automatic ucode_type ucode_rom(input upc_type addr);
      ucode_type w;
      w = '0;
      case (addr)
         U_DISP: begin
            w.cond = COND_DISPATCH;
         end
         U_NOP: begin
            w.done = 1'b1;
         end
         U_ERR_POS: begin
            w.status = ST_BAD_POS;
            w.done   = 1'b1;
         end
         U_ERR_FULL: begin
            w.status = ST_FULL;
            w.done   = 1'b1;
         end
         U_ERR_MISS: begin
            w.status = ST_NOT_FOUND;
            w.done   = 1'b1;
         end
         U_APP: begin
            w.wr_en  = 1'b1;
            w.wa_sel = WA_CNT;
            w.wd_sel = WD_VAL;
            w.cap_op = CAP_GROW;
            w.cnt_op = CNT_INC;
            w.done   = 1'b1;
         end
         U_INS: begin
            w.ptr_op = PTR_LOAD_CNT;
            w.cap_op = CAP_GROW;
         end
         U_INS_CHK: begin
            w.cond   = COND_PTR_LE_POS;
            w.target = U_INS_PUT;
         end
         U_INS_RD: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RA_PTR_M1;
         end
         U_INS_WB: begin
            w.wr_en  = 1'b1;
            w.wa_sel = WA_PTR;
            w.wd_sel = WD_RDATA;
            w.ptr_op = PTR_DEC;
            w.cond   = COND_ALWAYS;
            w.target = U_INS_CHK;
         end
         U_INS_PUT: begin
            w.wr_en  = 1'b1;
            w.wa_sel = WA_POS;
            w.wd_sel = WD_VAL;
            w.cnt_op = CNT_INC;
            w.done   = 1'b1;
         end
         U_DEL: begin
            w.ptr_op = PTR_LOAD_POS;
            w.cap_op = CAP_SHRINK;
         end
         U_DEL_CHK: begin
            w.cond   = COND_PTR_P1_GE_CNT;
            w.target = U_DEL_FIN;
         end
         U_DEL_RD: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RA_PTR_P1;
         end
         U_DEL_WB: begin
            w.wr_en  = 1'b1;
            w.wa_sel = WA_PTR;
            w.wd_sel = WD_RDATA;
            w.ptr_op = PTR_INC;
            w.cond   = COND_ALWAYS;
            w.target = U_DEL_CHK;
         end
         U_DEL_FIN: begin
            w.cnt_op = CNT_DEC;
            w.done   = 1'b1;
         end
         U_RD: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RA_POS;
         end
         U_RD_CAP: begin
            w.data_sel = DATA_RDATA;
            w.done     = 1'b1;
         end
         U_WR: begin
            w.wr_en  = 1'b1;
            w.wa_sel = WA_POS;
            w.wd_sel = WD_VAL;
            w.done   = 1'b1;
         end
         U_SRCH: begin
            w.ptr_op = PTR_ZERO;
         end
         U_SRCH_RD: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RA_PTR;
         end
         U_SRCH_CMP: begin
            w.cond   = COND_MATCH;
            w.target = U_SRCH_HIT;
         end
         U_SRCH_NXT: begin
            w.ptr_op = PTR_INC;
            w.cond   = COND_PTR_P1_LT_CNT;
            w.target = U_SRCH_RD;
         end
         U_SRCH_MISS: begin
            w.status = ST_NOT_FOUND;
            w.done   = 1'b1;
         end
         U_SRCH_HIT: begin
            w.data_sel = DATA_PTR;
            w.done     = 1'b1;
         end
         U_CLR: begin
            w.cnt_op = CNT_ZERO;
            w.cap_op = CAP_INIT;
            w.done   = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/indexed_list_insert_delete.sv -----
// indexed list insert/delete: a bounded ordered list of signed words
// request channel req_*, result channel rsp_*, one capacity register csr_*
// an item is taken when req_valid and req_ready are both high; exactly one
// result item comes back for each request item, in order
// the list lives in one simple dual-port ram; a microcode sequencer steps a
// small datapath (pointer, count, capacity) over it, one control word a cycle
// while no finishing step waits on a full output register
// each pass of a shift loop moves one entry (bound check, read, write-back),
// bounded by the single ram read port; one item is worked on at a time
// req_ready is low while an item is in work; it rises again once the result
// sits in the output register, so the next item can be taken while the
// receiver stalls; a finished item waits for the output register to empty
// reset (synchronous, active high) empties the list and loads 4 into the
// capacity register and the logical capacity; the ram is not cleared
// csr writes take effect at the next clear opcode
// depends on rtl/ilid_pkg.sv and rtl/ilid_ram.sv
module indexed_list_insert_delete
   import ilid_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_opcode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [WORD_W-1:0]  req_value,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic signed [WORD_W-1:0]  rsp_data,
   output logic [TOTAL_W-1:0]        rsp_entry_total,
   output logic [TOTAL_W-1:0]        rsp_logical_capacity,
   output logic                      rsp_is_empty,
   output logic                      rsp_is_full,
   // capacity register write
   input  logic                      csr_wr_en,
   input  logic [TOTAL_W-1:0]        csr_wr_data
);

   // count and pointer hold 0..DEPTH; compare width covers position too
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int EW    = CMP_W + 1;
   localparam int RESET_CAP_I = (DEPTH < int'(CSR_INIT_RESET)) ? DEPTH : int'(CSR_INIT_RESET);
   localparam logic [EW-1:0]    DEPTH_E   = EW'(DEPTH);
   localparam logic [EW-1:0]    ONE_E     = EW'(1);
   localparam logic [CNT_W-1:0] RESET_CAP = CNT_W'(RESET_CAP_I);

   // control state
   logic                   busy_ff,      busy_in;
   upc_type                upc_ff,       upc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]       cnt_ff,       cnt_in;
   logic [CNT_W-1:0]       cap_ff,       cap_in;
   logic [TOTAL_W-1:0]     init_cap_ff,  init_cap_in;

   // item and datapath registers
   logic [2:0]             op_ff,        op_in;
   logic [POS_W-1:0]       pos_ff,       pos_in;
   logic [WORD_W-1:0]      val_ff,       val_in;
   logic [CNT_W-1:0]       ptr_ff,       ptr_in;

   // result registers
   status_type             status_ff,    status_in;
   logic [WORD_W-1:0]      data_ff,      data_in;
   logic [TOTAL_W-1:0]     total_ff,     total_in;
   logic [TOTAL_W-1:0]     lcap_ff,      lcap_in;
   logic                   empty_ff,     empty_in;
   logic                   full_ff,      full_in;

   // current control word and step enable
   ucode_type              uw;
   logic                   step_go;
   logic                   cond_hit;
   upc_type                disp_target;

   // widened operands for compares
   logic [EW-1:0]          ptr_e, pos_e, cnt_e, cap_e, init_e;
   logic [EW-1:0]          ptr_m1_e, ptr_p1_e, cap_dbl_e;
   logic [EW-1:0]          cap_grow_e, cap_shrink_e, cap_init_e;
   logic                   store_full;

   // ram port
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [WORD_W-1:0]      ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [WORD_W-1:0]      ram_rd_data;

   ilid_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = !busy_ff;

   // capacity arithmetic
   always_comb begin
      ptr_e     = EW'(ptr_ff);
      pos_e     = EW'(pos_ff);
      cnt_e     = EW'(cnt_ff);
      cap_e     = EW'(cap_ff);
      init_e    = EW'(init_cap_ff);
      ptr_m1_e  = ptr_e - ONE_E;
      ptr_p1_e  = ptr_e + ONE_E;
      cap_dbl_e = cap_e << 1;

      // double when full, saturating at the store depth
      if (cnt_e >= cap_e) begin
         cap_grow_e = (cap_dbl_e > DEPTH_E) ? DEPTH_E : cap_dbl_e;
      end else begin
         cap_grow_e = cap_e;
      end

      // halve when the count sits at half the capacity
      if ((cnt_e == (cap_e >> 1)) && (cap_e > ONE_E)) begin
         cap_shrink_e = cap_e >> 1;
      end else begin
         cap_shrink_e = cap_e;
      end

      // register value clamped into 1..DEPTH
      if (init_e == '0) begin
         cap_init_e = ONE_E;
      end else if (init_e > DEPTH_E) begin
         cap_init_e = DEPTH_E;
      end else begin
         cap_init_e = init_e;
      end

      store_full = (cnt_e >= cap_e) && (cap_e >= DEPTH_E);
   end

   // opcode dispatch with the range checks folded in
   always_comb begin
      disp_target = U_NOP;
      case (op_type'(op_ff))
         OP_APPEND: begin
            disp_target = store_full ? U_ERR_FULL : U_APP;
         end
         OP_INSERT: begin
            if (pos_e > cnt_e) begin
               disp_target = U_ERR_POS;
            end else if (store_full) begin
               disp_target = U_ERR_FULL;
            end else begin
               disp_target = U_INS;
            end
         end
         OP_DELETE: begin
            disp_target = (pos_e >= cnt_e) ? U_ERR_POS : U_DEL;
         end
         OP_READ: begin
            disp_target = (pos_e >= cnt_e) ? U_ERR_POS : U_RD;
         end
         OP_OVERWRITE: begin
            disp_target = (pos_e >= cnt_e) ? U_ERR_POS : U_WR;
         end
         OP_SEARCH: begin
            disp_target = (cnt_e == '0) ? U_ERR_MISS : U_SRCH;
         end
         OP_CLEAR: begin
            disp_target = U_CLR;
         end
         default: begin
            disp_target = U_NOP;
         end
      endcase
   end

   // sequencer and datapath
   always_comb begin
      uw = ucode_rom(upc_ff);

      // a finishing step waits while the output register is still full
      step_go = busy_ff && (!uw.done || !rsp_valid_ff || rsp_ready);

      case (uw.cond)
         COND_PTR_LE_POS:    cond_hit = (ptr_e <= pos_e);
         COND_PTR_P1_GE_CNT: cond_hit = (ptr_p1_e >= cnt_e);
         COND_PTR_P1_LT_CNT: cond_hit = (ptr_p1_e < cnt_e);
         COND_MATCH:         cond_hit = (ram_rd_data == val_ff);
         COND_ALWAYS:        cond_hit = 1'b1;
         COND_DISPATCH:      cond_hit = 1'b1;
         default:            cond_hit = 1'b0;
      endcase

      // ram port
      ram_rd_en = step_go && uw.rd_en;
      case (uw.rd_sel)
         RA_PTR_M1: ram_rd_addr = ptr_m1_e[AW-1:0];
         RA_PTR_P1: ram_rd_addr = ptr_p1_e[AW-1:0];
         RA_POS:    ram_rd_addr = pos_e[AW-1:0];
         default:   ram_rd_addr = ptr_e[AW-1:0];
      endcase
      ram_wr_en = step_go && uw.wr_en;
      case (uw.wa_sel)
         WA_POS:  ram_wr_addr = pos_e[AW-1:0];
         WA_CNT:  ram_wr_addr = cnt_e[AW-1:0];
         default: ram_wr_addr = ptr_e[AW-1:0];
      endcase
      ram_wr_data = (uw.wd_sel == WD_RDATA) ? ram_rd_data : val_ff;

      // hold by default
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      ptr_in       = ptr_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      total_in     = total_ff;
      lcap_in      = lcap_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      init_cap_in  = csr_wr_en ? csr_wr_data : init_cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (step_go) begin
         case (uw.ptr_op)
            PTR_LOAD_POS: ptr_in = pos_e[CNT_W-1:0];
            PTR_LOAD_CNT: ptr_in = cnt_ff;
            PTR_ZERO:     ptr_in = '0;
            PTR_INC:      ptr_in = ptr_p1_e[CNT_W-1:0];
            PTR_DEC:      ptr_in = ptr_m1_e[CNT_W-1:0];
            default:      ptr_in = ptr_ff;
         endcase

         case (uw.cnt_op)
            CNT_INC:  cnt_in = cnt_ff + CNT_W'(1);
            CNT_DEC:  cnt_in = cnt_ff - CNT_W'(1);
            CNT_ZERO: cnt_in = '0;
            default:  cnt_in = cnt_ff;
         endcase

         case (uw.cap_op)
            CAP_GROW:   cap_in = cap_grow_e[CNT_W-1:0];
            CAP_SHRINK: cap_in = cap_shrink_e[CNT_W-1:0];
            CAP_INIT:   cap_in = cap_init_e[CNT_W-1:0];
            default:    cap_in = cap_ff;
         endcase

         if (uw.cond == COND_DISPATCH) begin
            upc_in = disp_target;
         end else if (cond_hit) begin
            upc_in = uw.target;
         end else begin
            upc_in = upc_ff + 5'd1;
         end

         // finishing step loads the result register
         if (uw.done) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
            status_in    = uw.status;
            case (uw.data_sel)
               DATA_RDATA: data_in = ram_rd_data;
               DATA_PTR:   data_in = WORD_W'(ptr_ff);
               default:    data_in = '0;
            endcase
            total_in = TOTAL_W'(cnt_in);
            lcap_in  = TOTAL_W'(cap_in);
            empty_in = (cnt_in == '0);
            full_in  = (cnt_in == cap_in);
         end
      end

      // new item; only possible while the sequencer is idle
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
         upc_in  = U_DISP;
         op_in   = req_opcode;
         pos_in  = req_position;
         val_in  = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= U_DISP;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         cap_ff       <= RESET_CAP;
         init_cap_ff  <= CSR_INIT_RESET;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         init_cap_ff  <= init_cap_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      total_ff  <= total_in;
      lcap_ff   <= lcap_in;
      empty_ff  <= empty_in;
      full_ff   <= full_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_data             = data_ff;
   assign rsp_entry_total      = total_ff;
   assign rsp_logical_capacity = lcap_ff;
   assign rsp_is_empty         = empty_ff;
   assign rsp_is_full          = full_ff;

endmodule

// ----- rtl/ilid_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module ilid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
